// ===== rtl/core/lbw_pkg.sv =====
// ----------------------------------------------------------------------------
// lbw_pkg
// Shared types and constants of the D2Q5 lattice Boltzmann wave step unit.
// ----------------------------------------------------------------------------
package lbw_pkg;

    localparam int COORD_W   = 6;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int REST_W    = 17;
    localparam int NDIR      = 5;
    localparam int DIR_W     = 3;

    localparam logic [DIR_W-1:0] DIR_LAST = DIR_W'(NDIR - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_C_SQ  = 3'd0,
        CFG_INV_TAU     = 3'd1,
        CFG_REST_WEIGHT = 3'd2,
        CFG_SOURCE_X    = 3'd3,
        CFG_SOURCE_Y    = 3'd4
    } lbw_cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_STEP = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } lbw_action_t;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [DATA_W-1:0]  density_value;
        logic signed [DATA_W-1:0]  current_x;
        logic signed [DATA_W-1:0]  current_y;
        logic [COORD_W-1:0]        cell_x;
        logic [COORD_W-1:0]        cell_y;
    } lbw_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  density;
        logic                      saturated;
    } lbw_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]      index;
        logic [DATA_W-1:0]         value;
    } lbw_cfg_t;

    // pipeline job kind
    typedef enum logic [1:0] {
        PM_COLLIDE = 2'd0,
        PM_EQ      = 2'd1,
        PM_SUM     = 2'd2
    } lbw_pmode_t;

    typedef struct packed {
        lbw_pmode_t mode;
        logic       src;
    } lbw_ctl_t;

    typedef struct packed {
        logic [NDIR-1:0][DATA_W-1:0] f;
        logic signed [DATA_W-1:0]    rho;
        logic signed [DATA_W-1:0]    jx;
        logic signed [DATA_W-1:0]    jy;
    } lbw_cell_t;

    typedef struct packed {
        logic                        valid;
        logic [DIR_W-1:0]            dir;
        logic signed [DATA_W-1:0]    data;
    } lbw_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RBASE,
        ST_RGATHER,
        ST_RWAIT,
        ST_INIT_EQ,
        ST_INIT_WAIT,
        ST_FILL,
        ST_COLLIDE,
        ST_CWAIT,
        ST_OVR,
        ST_OWAIT,
        ST_STREAM,
        ST_SWAIT,
        ST_FINISH
    } lbw_state_t;

endpackage

// ===== rtl/core/lbw_chan_if.sv =====
// ----------------------------------------------------------------------------
// lbw_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lbw_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lattice_boltzmann_wave_step_unit.sv =====
// ----------------------------------------------------------------------------
// lattice_boltzmann_wave_step_unit
// Periodic D2Q5 lattice Boltzmann wave grid in signed fixed point.
// ----------------------------------------------------------------------------
// One input transaction is one action and gives exactly one result
// transaction. Init writes the equilibrium of the given density and currents
// into every cell, one memory word per cycle. Step reads every distribution
// word once (collision pass) and every post-collision word once (streaming
// pass). Read sums the five post-collision words of one cell. Coordinates
// are wrapped by repeated subtraction at the start of each action on grids
// narrower than 64. Both state memories are undefined after reset: issue init
// before the first step and a step before the first read. Configuration
// registers may be written whenever no action is in flight.
// ----------------------------------------------------------------------------
module lattice_boltzmann_wave_step_unit #(
    parameter int GRID_X    = 64,
    parameter int GRID_Y    = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    lbw_chan_if.sink   in_ch,
    lbw_chan_if.source out_ch,
    lbw_chan_if.sink   cfg_ch
);
    import lbw_pkg::*;

    localparam int PLANE = GRID_X * GRID_Y * NDIR;   // words per memory
    localparam int ROW   = GRID_Y * NDIR;            // stride of one x step
    localparam int AW    = $clog2(PLANE);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]         tcs_reg, itau_reg;
    logic [REST_W-1:0]   w0_reg;
    logic [COORD_W-1:0]  srcx_cfg_reg, srcy_cfg_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcs_reg      <= 32'd49152;
            itau_reg     <= 32'd131072;
            w0_reg       <= 17'd21845;
            srcx_cfg_reg <= 6'd32;
            srcy_cfg_reg <= 6'd32;
        end
        else if (cfg_ch.valid)
        begin
            case (lbw_cfg_idx_t'(cfg_ch.data.index))
                CFG_THREE_C_SQ:  tcs_reg      <= cfg_ch.data.value;
                CFG_INV_TAU:     itau_reg     <= cfg_ch.data.value;
                CFG_REST_WEIGHT: w0_reg       <= cfg_ch.data.value[REST_W-1:0];
                CFG_SOURCE_X:    srcx_cfg_reg <= cfg_ch.data.value[COORD_W-1:0];
                CFG_SOURCE_Y:    srcy_cfg_reg <= cfg_ch.data.value[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State memories
    // ------------------------------------------------------------------
    logic          dist_we, dist_re, post_we, post_re;
    logic [AW-1:0] dist_waddr, dist_raddr, post_waddr, post_raddr;
    logic [31:0]   dist_wdata, dist_rdata, post_wdata, post_rdata;

    lbw_ram #(.DEPTH(PLANE), .AW(AW), .W(32)) u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    lbw_ram #(.DEPTH(PLANE), .AW(AW), .W(32)) u_post (
        .clk   (clk),
        .we    (post_we),
        .waddr (post_waddr),
        .wdata (post_wdata),
        .re    (post_re),
        .raddr (post_raddr),
        .rdata (post_rdata)
    );

    // ------------------------------------------------------------------
    // Cell pipeline
    // ------------------------------------------------------------------
    logic               pipe_ld, pipe_busy, pipe_sat, clr_sat;
    lbw_ctl_t           pipe_ctl;
    lbw_cell_t          pipe_cell;
    logic [AW-1:0]      pipe_base, res_addr;
    logic signed [31:0] pipe_rho, src_jx, src_jy;
    lbw_res_t           res;

    lbw_cell_pipe #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .tcs      (tcs_reg),
        .itau     (itau_reg),
        .w0       (w0_reg),
        .clr_sat  (clr_sat),
        .ld       (pipe_ld),
        .ld_ctl   (pipe_ctl),
        .ld_cell  (pipe_cell),
        .ld_base  (pipe_base),
        .busy     (pipe_busy),
        .rho      (pipe_rho),
        .src_jx   (src_jx),
        .src_jy   (src_jy),
        .res      (res),
        .res_addr (res_addr),
        .sat      (pipe_sat)
    );

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    lbw_state_t          state_reg, state_next;
    lbw_in_t             item_reg;
    logic [COORD_W-1:0]  rx_reg, ry_reg, sx_reg, sy_reg;
    logic [COORD_W-1:0]  rx_next, ry_next, sx_next, sy_next;
    logic [AW-1:0]       a_reg, a_next, cb_reg, cb_next, rbase_reg, rbase_next;
    logic [DIR_W-1:0]    d_reg, d_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [YW-1:0]       y_reg, y_next;

    // read tag, aligned with the registered memory read data
    logic                tag_v_reg, tag_v_next;
    logic                tag_post_reg, tag_post_next;
    logic                tag_src_reg, tag_src_next;
    logic [DIR_W-1:0]    tag_d_reg, tag_d_next;
    logic [AW-1:0]       tag_base_reg, tag_base_next;
    logic [3:0][31:0]    fbuf_reg;
    logic [AW-1:0]       src_base_reg;

    // streaming write, issued in the cycle after its post read
    logic                st_v_reg, st_v_next;
    logic [AW-1:0]       st_addr_reg, st_addr_next;

    logic [NDIR-1:0][31:0] eqinit_reg;
    logic                  out_v_reg;
    lbw_out_t              out_reg;

    logic                accept, advance, restart, sweep_last, red_busy, out_free;
    logic [AW-1:0]       nb_cell;
    logic [31:0]         rd_word;

    assign accept     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_free   = !out_v_reg || out_ch.ready;
    assign sweep_last = (a_reg == AW'(PLANE - 1));
    assign clr_sat    = accept;
    assign rd_word    = tag_post_reg ? post_rdata : dist_rdata;

    // coordinates taken modulo the grid by repeated subtraction
    always_comb
    begin
        rx_next  = (32'(rx_reg) >= GRID_X) ? rx_reg - COORD_W'(GRID_X) : rx_reg;
        ry_next  = (32'(ry_reg) >= GRID_Y) ? ry_reg - COORD_W'(GRID_Y) : ry_reg;
        sx_next  = (32'(sx_reg) >= GRID_X) ? sx_reg - COORD_W'(GRID_X) : sx_reg;
        sy_next  = (32'(sy_reg) >= GRID_Y) ? sy_reg - COORD_W'(GRID_Y) : sy_reg;
        red_busy = (32'(rx_reg) >= GRID_X) || (32'(ry_reg) >= GRID_Y)
                || (32'(sx_reg) >= GRID_X) || (32'(sy_reg) >= GRID_Y);
    end

    // base of the neighbouring cell in direction d, with wraparound
    always_comb
    begin
        case (d_reg)
            3'd1:    nb_cell = (x_reg == XW'(GRID_X - 1)) ? cb_reg - AW'(PLANE - ROW)
                                                          : cb_reg + AW'(ROW);
            3'd2:    nb_cell = (y_reg == YW'(GRID_Y - 1)) ? cb_reg - AW'(ROW - NDIR)
                                                          : cb_reg + AW'(NDIR);
            3'd3:    nb_cell = (x_reg == '0) ? cb_reg + AW'(PLANE - ROW)
                                             : cb_reg - AW'(ROW);
            3'd4:    nb_cell = (y_reg == '0) ? cb_reg + AW'(ROW - NDIR)
                                             : cb_reg - AW'(NDIR);
            default: nb_cell = cb_reg;
        endcase
    end

    // gather: four words buffered, the fifth launches the cell
    always_comb
    begin
        pipe_ld       = tag_v_reg && (tag_d_reg == DIR_LAST);
        pipe_ctl.mode = tag_post_reg ? PM_SUM : PM_COLLIDE;
        pipe_ctl.src  = tag_src_reg;
        pipe_cell.f   = {rd_word, fbuf_reg[3], fbuf_reg[2], fbuf_reg[1], fbuf_reg[0]};
        pipe_cell.rho = item_reg.density_value;
        pipe_cell.jx  = item_reg.current_x;
        pipe_cell.jy  = item_reg.current_y;
        pipe_base     = tag_base_reg;
        if (state_reg == ST_INIT_EQ)
        begin
            pipe_ld       = 1'b1;
            pipe_ctl.mode = PM_EQ;
            pipe_ctl.src  = 1'b0;
            pipe_base     = '0;
        end
        else if (state_reg == ST_OVR)
        begin
            pipe_ld       = 1'b1;
            pipe_ctl.mode = PM_EQ;
            pipe_ctl.src  = 1'b0;
            pipe_cell.jx  = src_jx;
            pipe_cell.jy  = src_jy;
            pipe_base     = src_base_reg;
        end
    end

    // post memory takes collision and source results; init results are kept
    assign post_we    = res.valid && (state_reg != ST_INIT_WAIT);
    assign post_waddr = res_addr;
    assign post_wdata = res.data;

    // ------------------------------------------------------------------
    // Next state and sweep control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        advance       = 1'b0;
        restart       = 1'b0;
        rbase_next    = rbase_reg;
        tag_v_next    = 1'b0;
        tag_post_next = 1'b0;
        tag_src_next  = 1'b0;
        tag_d_next    = d_reg;
        tag_base_next = cb_reg;
        st_v_next     = 1'b0;
        st_addr_next  = nb_cell + AW'(d_reg);
        dist_re       = 1'b0;
        dist_raddr    = a_reg;
        post_re       = 1'b0;
        post_raddr    = a_reg;
        dist_we       = st_v_reg;
        dist_waddr    = st_addr_reg;
        dist_wdata    = post_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!red_busy)
                begin
                    restart = 1'b1;
                    case (lbw_action_t'(item_reg.action))
                        ACT_INIT: state_next = ST_INIT_EQ;
                        ACT_STEP: state_next = ST_COLLIDE;
                        ACT_READ: state_next = ST_RBASE;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RBASE:
            begin
                rbase_next = AW'(32'(rx_reg) * ROW + 32'(ry_reg) * NDIR);
                state_next = ST_RGATHER;
            end
            ST_RGATHER:
            begin
                post_re       = 1'b1;
                post_raddr    = rbase_reg + AW'(d_reg);
                tag_v_next    = 1'b1;
                tag_post_next = 1'b1;
                tag_base_next = rbase_reg;
                advance       = 1'b1;
                if (d_reg == DIR_LAST)
                begin
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT:
            begin
                if (!tag_v_reg && !pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_INIT_EQ:
            begin
                state_next = ST_INIT_WAIT;
            end
            ST_INIT_WAIT:
            begin
                if (!pipe_busy)
                begin
                    restart    = 1'b1;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                dist_we    = 1'b1;
                dist_waddr = a_reg;
                dist_wdata = eqinit_reg[d_reg];
                advance    = 1'b1;
                if (sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COLLIDE:
            begin
                dist_re      = 1'b1;
                tag_v_next   = 1'b1;
                tag_src_next = (32'(x_reg) == 32'(sx_reg)) && (32'(y_reg) == 32'(sy_reg));
                advance      = 1'b1;
                if (sweep_last)
                begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT:
            begin
                if (!tag_v_reg && !pipe_busy)
                begin
                    state_next = ST_OVR;
                end
            end
            ST_OVR:
            begin
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (!pipe_busy)
                begin
                    restart    = 1'b1;
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                post_re   = 1'b1;
                st_v_next = 1'b1;
                advance   = 1'b1;
                if (sweep_last)
                begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // sweep counters: word, direction, cell base, cell coordinates
        a_next  = a_reg;
        d_next  = d_reg;
        cb_next = cb_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        if (restart)
        begin
            a_next  = '0;
            d_next  = '0;
            cb_next = '0;
            x_next  = '0;
            y_next  = '0;
        end
        else if (advance)
        begin
            a_next = a_reg + AW'(1);
            if (d_reg == DIR_LAST)
            begin
                d_next  = '0;
                cb_next = cb_reg + AW'(NDIR);
                if (y_reg == YW'(GRID_Y - 1))
                begin
                    y_next = '0;
                    x_next = x_reg + XW'(1);
                end
                else
                begin
                    y_next = y_reg + YW'(1);
                end
            end
            else
            begin
                d_next = d_reg + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tag_v_reg <= 1'b0;
            st_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            a_reg     <= '0;
            d_reg     <= '0;
            cb_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tag_v_reg <= tag_v_next;
            st_v_reg  <= st_v_next;
            a_reg     <= a_next;
            d_reg     <= d_next;
            cb_reg    <= cb_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_ch.data;
            rx_reg   <= in_ch.data.cell_x;
            ry_reg   <= in_ch.data.cell_y;
            sx_reg   <= srcx_cfg_reg;
            sy_reg   <= srcy_cfg_reg;
        end
        else if (state_reg == ST_REDUCE)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        rbase_reg    <= rbase_next;
        tag_post_reg <= tag_post_next;
        tag_src_reg  <= tag_src_next;
        tag_d_reg    <= tag_d_next;
        tag_base_reg <= tag_base_next;
        st_addr_reg  <= st_addr_next;
        if (tag_v_reg && (tag_d_reg != DIR_LAST))
        begin
            fbuf_reg[tag_d_reg[1:0]] <= rd_word;
        end
        if (pipe_ld && tag_v_reg && tag_src_reg)
        begin
            src_base_reg <= tag_base_reg;
        end
        if (res.valid && (state_reg == ST_INIT_WAIT))
        begin
            eqinit_reg[res.dir] <= res.data;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_reg.density   <= (lbw_action_t'(item_reg.action) == ACT_READ)
                                 ? pipe_rho : 32'sd0;
            out_reg.saturated <= pipe_sat;
        end
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.data  = out_reg;
endmodule

// ===== rtl/core/lbw_ram.sv =====
// ----------------------------------------------------------------------------
// lbw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbw_ram #(
    parameter int DEPTH = 20480,
    parameter int AW    = 15,
    parameter int W     = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/lbw_cell_pipe.sv =====
// ----------------------------------------------------------------------------
// lbw_cell_pipe
// Per-cell moments, equilibrium and BGK collision, one direction per cycle.
// ----------------------------------------------------------------------------
module lbw_cell_pipe #(
    parameter int FRAC_BITS = 16,
    parameter int AW        = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           tcs,
    input  logic [31:0]           itau,
    input  logic [16:0]           w0,
    input  logic                  clr_sat,
    input  logic                  ld,
    input  lbw_pkg::lbw_ctl_t     ld_ctl,
    input  lbw_pkg::lbw_cell_t    ld_cell,
    input  logic [AW-1:0]         ld_base,
    output logic                  busy,
    output logic signed [31:0]    rho,
    output logic signed [31:0]    src_jx,
    output logic signed [31:0]    src_jy,
    output lbw_pkg::lbw_res_t     res,
    output logic [AW-1:0]         res_addr,
    output logic                  sat
);
    import lbw_pkg::*;

    localparam logic signed [33:0] ONE = 34'(64'(1) << FRAC_BITS);

    // {saturated, value}
    function automatic logic [32:0] clamp32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
        begin
            return {1'b1, 32'h7fff_ffff};
        end
        else if (v < -68'sd2147483648)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // product shifted down with floor rounding, then clamped
    function automatic logic [32:0] qmul(input logic signed [33:0] a,
                                         input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    // config-derived constants
    logic signed [33:0] tcs_s, itau_s, rem;
    logic [32:0]        prod_reg, aux_reg;
    logic signed [33:0] wm_reg, keep_reg;

    assign tcs_s  = {2'b00, tcs};
    assign itau_s = {2'b00, itau};
    assign rem    = ONE - {17'b0, w0};

    always_ff @(posedge clk)
    begin
        prod_reg <= qmul(rem, tcs_s);
        aux_reg  <= clamp32(68'(ONE) - 68'($signed(prod_reg[31:0])))
                    | {prod_reg[32], 32'b0};
        wm_reg   <= rem >>> 2;
        keep_reg <= ONE - itau_s;
    end

    // stage 1: moments
    logic [32:0] c_rho, c_jx, c_jy;
    logic        flag1;

    always_comb
    begin
        c_rho = clamp32(68'($signed(ld_cell.f[0])) + 68'($signed(ld_cell.f[1]))
                      + 68'($signed(ld_cell.f[2])) + 68'($signed(ld_cell.f[3]))
                      + 68'($signed(ld_cell.f[4])));
        c_jx  = clamp32(68'($signed(ld_cell.f[1])) - 68'($signed(ld_cell.f[3])));
        c_jy  = clamp32(68'($signed(ld_cell.f[2])) - 68'($signed(ld_cell.f[4])));
        flag1 = ld && (((ld_ctl.mode != PM_EQ) && c_rho[32])
                || ((ld_ctl.mode == PM_COLLIDE) && (c_jx[32] || c_jy[32])));
    end

    logic                        v1_reg;
    lbw_pmode_t                  mode1_reg;
    logic signed [31:0]          rho1_reg, jx1_reg, jy1_reg;
    logic [NDIR-1:0][31:0]       f1_reg;
    logic [AW-1:0]               base1_reg;
    logic signed [31:0]          sjx_reg, sjy_reg;

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            mode1_reg <= ld_ctl.mode;
            f1_reg    <= ld_cell.f;
            base1_reg <= ld_base;
            if (ld_ctl.mode == PM_EQ)
            begin
                rho1_reg <= ld_cell.rho;
                jx1_reg  <= ld_cell.jx;
                jy1_reg  <= ld_cell.jy;
            end
            else
            begin
                rho1_reg <= c_rho[31:0];
                jx1_reg  <= c_jx[31:0];
                jy1_reg  <= c_jy[31:0];
            end
            if (ld_ctl.src && (ld_ctl.mode == PM_COLLIDE))
            begin
                sjx_reg <= c_jx[31:0];
                sjy_reg <= c_jy[31:0];
            end
        end
    end

    // stage 2: rho times 3c^2, then held while five directions stream out
    logic [32:0]                 m2;
    logic                        ld2, flag2;
    logic                        busy2_reg;
    logic [DIR_W-1:0]            d2_reg;
    lbw_pmode_t                  mode2_reg;
    logic signed [31:0]          rhot2_reg, rho2_reg, jx2_reg, jy2_reg;
    logic [NDIR-1:0][31:0]       f2_reg;
    logic [AW-1:0]               base2_reg;

    assign m2    = qmul(34'(rho1_reg), tcs_s);
    assign ld2   = v1_reg && (mode1_reg != PM_SUM);
    assign flag2 = ld2 && m2[32];

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            rhot2_reg <= m2[31:0];
            rho2_reg  <= rho1_reg;
            jx2_reg   <= jx1_reg;
            jy2_reg   <= jy1_reg;
            f2_reg    <= f1_reg;
            base2_reg <= base1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // stage 3: equilibrium operands for direction d2
    logic signed [67:0] dot68;
    logic [32:0]        inner;
    logic               flag3;

    always_comb
    begin
        case (d2_reg)
            3'd1:    dot68 = 68'(jx2_reg);
            3'd2:    dot68 = 68'(jy2_reg);
            3'd3:    dot68 = -68'(jx2_reg);
            3'd4:    dot68 = -68'(jy2_reg);
            default: dot68 = '0;
        endcase
        inner = clamp32(68'(rhot2_reg) + dot68 * 68'sd3);
        flag3 = busy2_reg && (d2_reg != '0) && inner[32];
    end

    logic                  v3_reg;
    logic [DIR_W-1:0]      d3_reg;
    lbw_pmode_t            mode3_reg;
    logic [AW-1:0]         addr3_reg;
    logic signed [31:0]    f3_reg;
    logic signed [33:0]    opa3_reg, opb3_reg;

    always_ff @(posedge clk)
    begin
        if (busy2_reg)
        begin
            d3_reg    <= d2_reg;
            mode3_reg <= mode2_reg;
            addr3_reg <= base2_reg + AW'(d2_reg);
            f3_reg    <= f2_reg[d2_reg];
            if (d2_reg == '0)
            begin
                opa3_reg <= 34'(rho2_reg);
                opb3_reg <= 34'($signed(aux_reg[31:0]));
            end
            else
            begin
                opa3_reg <= 34'($signed(inner[31:0]));
                opb3_reg <= wm_reg;
            end
        end
    end

    // stage 4: equilibrium and kept part of f
    logic [32:0] q_eq, q_fk;
    logic        flag4;

    assign q_eq  = qmul(opa3_reg, opb3_reg);
    assign q_fk  = qmul(34'(f3_reg), keep_reg);
    assign flag4 = v3_reg && (q_eq[32] || ((d3_reg == '0) && aux_reg[32])
                   || ((mode3_reg == PM_COLLIDE) && q_fk[32]));

    logic                  v4_reg;
    logic [DIR_W-1:0]      d4_reg;
    lbw_pmode_t            mode4_reg;
    logic [AW-1:0]         addr4_reg;
    logic signed [31:0]    eq4_reg, fk4_reg;

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            d4_reg    <= d3_reg;
            mode4_reg <= mode3_reg;
            addr4_reg <= addr3_reg;
            eq4_reg   <= q_eq[31:0];
            fk4_reg   <= q_fk[31:0];
        end
    end

    // stage 5: relaxed part of equilibrium
    logic [32:0] q_ei;
    logic        flag5;

    assign q_ei  = qmul(34'(eq4_reg), itau_s);
    assign flag5 = v4_reg && (mode4_reg == PM_COLLIDE) && q_ei[32];

    logic                  v5_reg;
    logic [DIR_W-1:0]      d5_reg;
    lbw_pmode_t            mode5_reg;
    logic [AW-1:0]         addr5_reg;
    logic signed [31:0]    eq5_reg, fk5_reg, ei5_reg;

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            d5_reg    <= d4_reg;
            mode5_reg <= mode4_reg;
            addr5_reg <= addr4_reg;
            eq5_reg   <= eq4_reg;
            fk5_reg   <= fk4_reg;
            ei5_reg   <= q_ei[31:0];
        end
    end

    logic [32:0] fin;
    logic        flag6;

    assign fin   = clamp32(68'(fk5_reg) + 68'(ei5_reg));
    assign flag6 = v5_reg && (mode5_reg == PM_COLLIDE) && fin[32];

    // control state
    logic sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            busy2_reg <= 1'b0;
            d2_reg    <= '0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= ld;
            v3_reg <= busy2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (ld2)
            begin
                busy2_reg <= 1'b1;
                d2_reg    <= '0;
            end
            else if (busy2_reg)
            begin
                d2_reg <= d2_reg + 3'd1;
                if (d2_reg == DIR_LAST)
                begin
                    busy2_reg <= 1'b0;
                end
            end
            if (clr_sat)
            begin
                sat_reg <= 1'b0;
            end
            else
            begin
                sat_reg <= sat_reg | flag1 | flag2 | flag3 | flag4 | flag5 | flag6;
            end
        end
    end

    assign busy      = v1_reg | busy2_reg | v3_reg | v4_reg | v5_reg;
    assign rho       = rho1_reg;
    assign src_jx    = sjx_reg;
    assign src_jy    = sjy_reg;
    assign res.valid = v5_reg;
    assign res.dir   = d5_reg;
    assign res.data  = (mode5_reg == PM_COLLIDE) ? $signed(fin[31:0]) : eq5_reg;
    assign res_addr  = addr5_reg;
    assign sat       = sat_reg;
endmodule
